>>> rtl/sfda_pkg.sv
`default_nettype none
package sfda_pkg;

	localparam int HISTORY_DEPTH = 8192;
	localparam int SAMPLE_BITS   = 24;
	localparam int ADDR_BITS     = $clog2(HISTORY_DEPTH);

	localparam int TARGET_BITS = 23;
	localparam int COEF_BITS   = 16;
	localparam int FRAC_BITS   = 20;
	localparam int DELAY_BITS  = 33;
	localparam int WHOLE_BITS  = DELAY_BITS - FRAC_BITS;
	localparam int TARGET_SHIFT = DELAY_BITS - TARGET_BITS;

	localparam logic [COEF_BITS-1:0]   COEF_RESET   = 16'd66;
	localparam logic [TARGET_BITS-1:0] TARGET_LIMIT = 23'd8126464;

	// shared multiplier
	localparam int MUL_A_BITS = 26;
	localparam int MUL_B_BITS = (SAMPLE_BITS > 24) ? SAMPLE_BITS : 24;
	localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

	localparam int LAG_BITS    = 22;
	localparam int PAIR_BITS   = 43;
	localparam int HALF_BITS   = 22;
	localparam int COEF_Q_BITS = 23;
	localparam int NUM_BITS    = 64;
	localparam int T_BITS      = 23;
	localparam int ACC_BITS    = PROD_BITS + 2;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left;
		logic signed [SAMPLE_BITS-1:0] right;
		logic [DELAY_BITS-1:0]         target;
	} item_t;

	// exact floor(t / 3) for t < 2^23
	function automatic logic [T_BITS-1:0] div3(input logic [T_BITS-1:0] t);
		logic [47:0] p;
		p = {25'd0, t} * 48'd5592406;
		return p[46:24];
	endfunction

endpackage
`default_nettype wire

>>> rtl/sfda_in_if.sv
`default_nettype none
interface sfda_in_if;
	import sfda_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_left;
	logic signed [SAMPLE_BITS-1:0] sample_right;
	logic [TARGET_BITS-1:0]        goal_delay;
	modport source (output valid, sample_left, sample_right, goal_delay, input ready);
	modport sink (input valid, sample_left, sample_right, goal_delay, output ready);
endinterface
`default_nettype wire

>>> rtl/sfda_out_if.sv
`default_nettype none
interface sfda_out_if;
	import sfda_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] delayed_left;
	logic signed [SAMPLE_BITS-1:0] delayed_right;
	modport source (output valid, delayed_left, delayed_right, input ready);
	modport sink (input valid, delayed_left, delayed_right, output ready);
endinterface
`default_nettype wire

>>> rtl/smoothed_fractional_delay_aligner_top.sv
// channel  dir  payload
// in_ch    in   sample_left, sample_right (Q1.23), goal_delay (Q13.10)
// out_ch   out  delayed_left, delayed_right (Q1.23, saturated)
// cfg      in   cfg_we / cfg_wdata: smoothing coefficient, Q0.16
//
// In the back end, one shared 26x24 multiplier does the
// smoothing step, the Lagrange coefficients and eight MACs in sequence.
// A two-entry queue takes items while the back end works; one result register
// holds a finished item, and the back end waits in its last step if it is full.
// Reset clears control only; history entries not yet written read as zero.
`default_nettype none
module smoothed_fractional_delay_aligner_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sfda_pkg::COEF_BITS-1:0] cfg_wdata,
	sfda_in_if.sink                             in_ch,
	sfda_out_if.source                          out_ch
);
	import sfda_pkg::*;

	item_t head;
	logic  head_valid;
	logic  pop;

	sfda_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	sfda_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule
`default_nettype wire

>>> rtl/sfda_front.sv
`default_nettype none
module sfda_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	sfda_in_if.sink             in_ch,
	output sfda_pkg::item_t     head,
	output logic                head_valid,
	input  wire logic           pop
);
	import sfda_pkg::*;

	item_t                  q_q [2];
	logic                   rd_ptr_q;
	logic                   wr_ptr_q;
	logic [1:0]             cnt_q;
	logic [TARGET_BITS-1:0] tgt;
	item_t                  item;
	logic                   push;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;

	// target saturates, then moves to Q13.20
	assign tgt         = (in_ch.goal_delay > TARGET_LIMIT) ? TARGET_LIMIT : in_ch.goal_delay;
	assign item.left   = in_ch.sample_left;
	assign item.right  = in_ch.sample_right;
	assign item.target = {tgt, {TARGET_SHIFT{1'b0}}};

	assign head       = q_q[rd_ptr_q];
	assign head_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/sfda_back.sv
`default_nettype none
module sfda_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [sfda_pkg::COEF_BITS-1:0] cfg_wdata,
	input  wire sfda_pkg::item_t             head,
	input  wire logic                        head_valid,
	output logic                             pop,
	sfda_out_if.source                       out_ch
);
	import sfda_pkg::*;

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_SM_HI  = 5'd1;
	localparam logic [4:0] ST_SM_SUM = 5'd2;
	localparam logic [4:0] ST_SM_UPD = 5'd3;
	localparam logic [4:0] ST_FRAC   = 5'd4;
	localparam logic [4:0] ST_TAP0   = 5'd5;
	localparam logic [4:0] ST_CAP0   = 5'd6;
	localparam logic [4:0] ST_BC_LO  = 5'd8;
	localparam logic [4:0] ST_BC_HI  = 5'd9;
	localparam logic [4:0] ST_AC_LO  = 5'd10;
	localparam logic [4:0] ST_AC_HI  = 5'd11;
	localparam logic [4:0] ST_ABE_LO = 5'd12;
	localparam logic [4:0] ST_ABE_HI = 5'd13;
	localparam logic [4:0] ST_ABC_LO = 5'd14;
	localparam logic [4:0] ST_ABC_HI = 5'd15;
	localparam logic [4:0] ST_FIN_A  = 5'd16;
	localparam logic [4:0] ST_FIN_B  = 5'd17;
	localparam logic [4:0] ST_FIN_C  = 5'd18;
	localparam logic [4:0] ST_MAC0   = 5'd19;
	localparam logic [4:0] ST_MAC7   = 5'd26;
	localparam logic [4:0] ST_ACC7   = 5'd27;
	localparam logic [4:0] ST_OUT    = 5'd28;

	localparam int SPLIT = 17;
	localparam logic [DELAY_BITS-1:0] DELAY_ONE = DELAY_BITS'(1) << FRAC_BITS;
	localparam logic signed [LAG_BITS-1:0] LAG_ONE = LAG_BITS'(1) << FRAC_BITS;
	localparam logic [NUM_BITS-1:0] BIAS6 = NUM_BITS'(3) << 40;
	localparam logic [NUM_BITS-1:0] BIAS2 = NUM_BITS'(1) << 40;
	localparam logic [ACC_BITS-1:0] SAT_POS = ACC_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic [ACC_BITS-1:0] SAT_NEG = ACC_BITS'(64'd1 << (SAMPLE_BITS - 1));

	function automatic logic signed [SAMPLE_BITS-1:0] out_round(
		input logic signed [ACC_BITS-1:0] v);
		logic [ACC_BITS-1:0] mag;
		logic [ACC_BITS-1:0] r;
		logic                neg;
		neg = v[ACC_BITS-1];
		mag = neg ? ACC_BITS'(-v) : ACC_BITS'(v);
		r   = (mag + (ACC_BITS'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (!neg && r > SAT_POS) begin
			return SAT_POS[SAMPLE_BITS-1:0];
		end else if (neg && r > SAT_NEG) begin
			return SAT_NEG[SAMPLE_BITS-1:0];
		end else if (neg) begin
			return -r[SAMPLE_BITS-1:0];
		end
		return r[SAMPLE_BITS-1:0];
	endfunction

	// control
	logic [4:0]            st_q;
	logic [COEF_BITS-1:0]  coef_q;
	logic [DELAY_BITS-1:0] sdel_q;
	logic [ADDR_BITS-1:0]  wpos_q;
	logic                  full_q;

	// datapath
	logic                          dneg_q;
	logic signed [PROD_BITS-1:0]   prod_q;
	logic signed [PROD_BITS-1:0]   lo_q;
	logic [PROD_BITS-1:0]          sacc_q;
	logic [FRAC_BITS-1:0]          d_q;
	logic [WHOLE_BITS-1:0]         whole_q;
	logic signed [PAIR_BITS-1:0]   p_bc_q;
	logic signed [PAIR_BITS-1:0]   p_ab_q;
	logic signed [PAIR_BITS-1:0]   p_ac_q;
	logic signed [SAMPLE_BITS-1:0] tap_l_q [4];
	logic signed [SAMPLE_BITS-1:0] tap_r_q [4];
	logic signed [COEF_Q_BITS-1:0] cf_q [4];
	logic signed [ACC_BITS-1:0]    acc_l_q;
	logic signed [ACC_BITS-1:0]    acc_r_q;
	logic signed [NUM_BITS-1:0]    num_s1;
	logic [T_BITS-1:0]             t_s2;
	logic                          sgn_s2;
	logic                          div6_s2;

	logic signed [SAMPLE_BITS-1:0] mem_l [HISTORY_DEPTH];
	logic signed [SAMPLE_BITS-1:0] mem_r [HISTORY_DEPTH];
	logic signed [SAMPLE_BITS-1:0] rdl_q;
	logic signed [SAMPLE_BITS-1:0] rdr_q;
	logic                          rd_ok_q;

	logic signed [DELAY_BITS:0]    diff;
	logic                          dneg;
	logic [DELAY_BITS:0]           dmag;
	logic [PROD_BITS-1:0]          sround;
	logic [DELAY_BITS-1:0]         stepm;
	logic [DELAY_BITS-1:0]         applied;
	logic signed [LAG_BITS-1:0]    op_a;
	logic signed [LAG_BITS-1:0]    op_b;
	logic signed [LAG_BITS-1:0]    op_c;
	logic signed [LAG_BITS-1:0]    op_e;
	logic [ADDR_BITS-1:0]          base;
	logic [ADDR_BITS-1:0]          rd_addr;
	logic [1:0]                    tap_j;
	logic [1:0]                    cap_j;
	logic [2:0]                    mac_m;
	logic [2:0]                    acc_m;
	logic [1:0]                    f1_k;
	logic [1:0]                    f2_k;
	logic                          f1_div6;
	logic                          f1_neg;
	logic [NUM_BITS-1:0]           fmag;
	logic [NUM_BITS-1:0]           fsum;
	logic [T_BITS-1:0]             fq;
	logic signed [MUL_A_BITS-1:0]  mul_a;
	logic signed [MUL_B_BITS-1:0]  mul_b;
	logic                          out_free;
	logic                          mem_we;

	assign diff = $signed({1'b0, head.target}) - $signed({1'b0, sdel_q});
	assign dneg = diff[DELAY_BITS];
	assign dmag = dneg ? (DELAY_BITS + 1)'(-diff) : (DELAY_BITS + 1)'(diff);

	assign sround  = sacc_q + (PROD_BITS'(1) << (COEF_BITS - 1));
	assign stepm   = DELAY_BITS'(sround >> COEF_BITS);
	assign applied = (sdel_q < DELAY_ONE) ? DELAY_ONE : sdel_q;

	assign op_b = $signed({2'b00, d_q});
	assign op_a = op_b + LAG_ONE;
	assign op_c = op_b - LAG_ONE;
	assign op_e = op_b - (LAG_ONE <<< 1);

	// tap j sits at w + 1 - whole - j, modulo the depth
	assign tap_j   = 2'(st_q - ST_TAP0);
	assign cap_j   = 2'(st_q - ST_CAP0);
	assign base    = wpos_q + ADDR_BITS'(1) - ADDR_BITS'(whole_q);
	assign rd_addr = base - ADDR_BITS'(tap_j);

	assign mac_m = 3'(st_q - ST_MAC0);
	assign acc_m = 3'(st_q - ST_MAC0 - 5'd1);

	// coefficient finisher: order is c_m1, c_0, c_p1, c_p2
	assign f1_k    = 2'((st_q - ST_AC_HI) >> 1);
	assign f2_k    = 2'((st_q - ST_ABE_LO) >> 1);
	assign f1_div6 = (f1_k == 2'd0) || (f1_k == 2'd3);
	assign f1_neg  = (f1_k == 2'd0) || (f1_k == 2'd2);
	assign fmag    = num_s1[NUM_BITS-1] ? NUM_BITS'(-num_s1) : NUM_BITS'(num_s1);
	assign fsum    = fmag + (f1_div6 ? BIAS6 : BIAS2);
	assign fq      = div6_s2 ? div3(t_s2) : t_s2;

	assign out_free = !out_ch.valid || out_ch.ready;
	assign pop      = (st_q == ST_OUT) && out_free;
	assign mem_we   = (st_q == ST_IDLE) && head_valid;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			ST_IDLE: begin
				mul_a = MUL_A_BITS'({1'b0, coef_q});
				mul_b = MUL_B_BITS'({1'b0, dmag[SPLIT-1:0]});
			end
			ST_SM_HI: begin
				mul_a = MUL_A_BITS'({1'b0, coef_q});
				mul_b = MUL_B_BITS'({1'b0, dmag[DELAY_BITS-1:SPLIT]});
			end
			ST_TAP0: begin
				mul_a = MUL_A_BITS'(op_b);
				mul_b = MUL_B_BITS'(op_c);
			end
			ST_TAP0 + 5'd1: begin
				mul_a = MUL_A_BITS'(op_a);
				mul_b = MUL_B_BITS'(op_b);
			end
			ST_TAP0 + 5'd2: begin
				mul_a = MUL_A_BITS'(op_a);
				mul_b = MUL_B_BITS'(op_c);
			end
			ST_BC_LO: begin
				mul_a = MUL_A_BITS'({1'b0, p_bc_q[HALF_BITS-1:0]});
				mul_b = MUL_B_BITS'(op_e);
			end
			ST_BC_HI: begin
				mul_a = MUL_A_BITS'($signed(p_bc_q[PAIR_BITS-1:HALF_BITS]));
				mul_b = MUL_B_BITS'(op_e);
			end
			ST_AC_LO: begin
				mul_a = MUL_A_BITS'({1'b0, p_ac_q[HALF_BITS-1:0]});
				mul_b = MUL_B_BITS'(op_e);
			end
			ST_AC_HI: begin
				mul_a = MUL_A_BITS'($signed(p_ac_q[PAIR_BITS-1:HALF_BITS]));
				mul_b = MUL_B_BITS'(op_e);
			end
			ST_ABE_LO: begin
				mul_a = MUL_A_BITS'({1'b0, p_ab_q[HALF_BITS-1:0]});
				mul_b = MUL_B_BITS'(op_e);
			end
			ST_ABE_HI: begin
				mul_a = MUL_A_BITS'($signed(p_ab_q[PAIR_BITS-1:HALF_BITS]));
				mul_b = MUL_B_BITS'(op_e);
			end
			ST_ABC_LO: begin
				mul_a = MUL_A_BITS'({1'b0, p_ab_q[HALF_BITS-1:0]});
				mul_b = MUL_B_BITS'(op_c);
			end
			ST_ABC_HI: begin
				mul_a = MUL_A_BITS'($signed(p_ab_q[PAIR_BITS-1:HALF_BITS]));
				mul_b = MUL_B_BITS'(op_c);
			end
			ST_MAC0, ST_MAC0 + 5'd1, ST_MAC0 + 5'd2, ST_MAC0 + 5'd3,
			ST_MAC0 + 5'd4, ST_MAC0 + 5'd5, ST_MAC0 + 5'd6, ST_MAC7: begin
				mul_a = MUL_A_BITS'(cf_q[mac_m[1:0]]);
				mul_b = mac_m[2] ? MUL_B_BITS'(tap_r_q[mac_m[1:0]])
				                 : MUL_B_BITS'(tap_l_q[mac_m[1:0]]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// history stores, never cleared: entries not yet written read as zero
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_l[wpos_q] <= head.left;
			mem_r[wpos_q] <= head.right;
		end
		rdl_q   <= mem_l[rd_addr];
		rdr_q   <= mem_r[rd_addr];
		rd_ok_q <= full_q || (rd_addr <= wpos_q);
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
		if (st_q == ST_IDLE) begin
			dneg_q <= dneg;
		end
		if (st_q == ST_SM_HI || st_q == ST_BC_HI || st_q == ST_AC_HI ||
		    st_q == ST_ABE_HI || st_q == ST_ABC_HI) begin
			lo_q <= prod_q;
		end
		if (st_q == ST_SM_SUM) begin
			sacc_q <= PROD_BITS'(lo_q + (prod_q <<< SPLIT));
		end
		if (st_q == ST_FRAC) begin
			d_q     <= applied[FRAC_BITS-1:0];
			whole_q <= applied[DELAY_BITS-1:FRAC_BITS];
		end
		if (st_q == ST_CAP0) begin
			p_bc_q <= prod_q[PAIR_BITS-1:0];
		end
		if (st_q == ST_CAP0 + 5'd1) begin
			p_ab_q <= prod_q[PAIR_BITS-1:0];
		end
		if (st_q == ST_BC_LO) begin
			p_ac_q <= prod_q[PAIR_BITS-1:0];
		end
		if (st_q >= ST_CAP0 && st_q <= ST_BC_HI) begin
			tap_l_q[cap_j] <= rd_ok_q ? rdl_q : '0;
			tap_r_q[cap_j] <= rd_ok_q ? rdr_q : '0;
		end
		if (st_q == ST_AC_LO || st_q == ST_ABE_LO || st_q == ST_ABC_LO || st_q == ST_FIN_A) begin
			num_s1 <= NUM_BITS'(lo_q) + (NUM_BITS'(prod_q) <<< HALF_BITS);
		end
		if (st_q == ST_AC_HI || st_q == ST_ABE_HI || st_q == ST_ABC_HI || st_q == ST_FIN_B) begin
			t_s2    <= fsum[NUM_BITS-1:NUM_BITS-T_BITS];
			sgn_s2  <= num_s1[NUM_BITS-1] ^ f1_neg;
			div6_s2 <= f1_div6;
		end
		if (st_q == ST_ABE_LO || st_q == ST_ABC_LO || st_q == ST_FIN_A || st_q == ST_FIN_C) begin
			cf_q[f2_k] <= sgn_s2 ? -$signed(fq) : $signed(fq);
		end
		if (st_q == ST_MAC0) begin
			acc_l_q <= '0;
			acc_r_q <= '0;
		end
		if (st_q > ST_MAC0 && st_q <= ST_ACC7) begin
			if (acc_m[2]) begin
				acc_r_q <= acc_r_q + ACC_BITS'(prod_q);
			end else begin
				acc_l_q <= acc_l_q + ACC_BITS'(prod_q);
			end
		end
		if (pop) begin
			out_ch.delayed_left  <= out_round(acc_l_q);
			out_ch.delayed_right <= out_round(acc_r_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			coef_q       <= COEF_RESET;
			sdel_q       <= '0;
			wpos_q       <= '0;
			full_q       <= 1'b0;
			out_ch.valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				coef_q <= cfg_wdata;
			end
			if (st_q == ST_SM_UPD) begin
				sdel_q <= dneg_q ? sdel_q - stepm : sdel_q + stepm;
			end
			out_ch.valid <= pop || (out_ch.valid && !out_ch.ready);
			case (st_q)
				ST_IDLE: begin
					if (head_valid) begin
						st_q <= ST_SM_HI;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						wpos_q <= wpos_q + ADDR_BITS'(1);
						full_q <= full_q || (wpos_q == ADDR_BITS'(HISTORY_DEPTH - 1));
						st_q   <= ST_IDLE;
					end
				end
				default: begin
					st_q <= st_q + 5'd1;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
